@@ rtl/gpms_pkg.sv @@
// ============================================================================
// gpms_pkg - shared types and constants for the goal to polar move sequencer
// Fixed-point widths, CORDIC angle table, state encodings and result struct.
// ============================================================================
package gpms_pkg;

    localparam int GPMS_COORD_WIDTH  = 16;
    localparam int GPMS_CORDIC_STEPS = 16;

    // coordinates enter the CORDIC scaled by 2^GUARD_BITS
    localparam int GUARD_BITS  = 12;
    // angle accumulator in units of 2^-30 rad, wide enough for +-(pi/2 + sum atan)
    localparam int ANGLE_WIDTH = 33;
    localparam int DIST_WIDTH  = 17;
    localparam int HEAD_WIDTH  = 16;

    localparam logic [ANGLE_WIDTH-1:0] HALF_PI_Q30  = 33'd1686629713;
    localparam logic [HEAD_WIDTH-1:0]  PI_Q13       = 16'd25736;
    localparam logic [31:0]            INV_GAIN_Q32 = 32'd2608131496;

    // gain-corrected magnitude: bits [PROD_ROUND_BIT+17:PROD_ROUND_BIT] of x * INV_GAIN
    localparam int PROD_ROUND_BIT = GUARD_BITS + 31;
    localparam int PROD_BITS      = PROD_ROUND_BIT + DIST_WIDTH + 1;
    // heading: bits [ANG_ROUND_BIT+16:ANG_ROUND_BIT] of |z|
    localparam int ANG_ROUND_BIT  = 16;

    localparam logic CMD_GOAL     = 1'b0;
    localparam logic CMD_ACK      = 1'b1;
    localparam logic KIND_MOVE    = 1'b0;
    localparam logic KIND_REACHED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SOLVE,
        ST_EMIT_MOVE,
        ST_EMIT_REACH
    } gpms_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_POST,
        CS_DONE
    } gpms_cstate_t;

    typedef struct packed {
        logic                         done;
        logic [DIST_WIDTH-1:0]        distance;
        logic signed [HEAD_WIDTH-1:0] heading;
    } gpms_polar_t;

    // arctangent of 2^-i in units of 2^-30 rad, rounded to nearest
    function automatic logic [ANGLE_WIDTH-1:0] atan_entry(input logic [4:0] i);
        logic [ANGLE_WIDTH-1:0] v;
        unique case (i)
            5'd0:    v = 33'd843314857;
            5'd1:    v = 33'd497837829;
            5'd2:    v = 33'd263043837;
            5'd3:    v = 33'd133525159;
            5'd4:    v = 33'd67021687;
            5'd5:    v = 33'd33543516;
            5'd6:    v = 33'd16775851;
            5'd7:    v = 33'd8388437;
            5'd8:    v = 33'd4194283;
            5'd9:    v = 33'd2097149;
            5'd31:   v = '0;
            default: v = ANGLE_WIDTH'(1) << (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

@@ rtl/gpms_goal_if.sv @@
// ============================================================================
// gpms_goal_if - goal / acknowledgement channel
// Valid-ready channel carrying a command bit, a goal point and a framing bit.
// ============================================================================
interface gpms_goal_if
    import gpms_pkg::*;
#(
    parameter int COORD_WIDTH = GPMS_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [COORD_WIDTH-1:0] goal_x;
    logic signed [COORD_WIDTH-1:0] goal_y;
    logic                          last;

    modport source (output valid, cmd, goal_x, goal_y, last, input ready);
    modport sink   (input valid, cmd, goal_x, goal_y, last, output ready);
endinterface

@@ rtl/gpms_move_if.sv @@
// ============================================================================
// gpms_move_if - move command / goal reached channel
// Valid-ready channel carrying the result kind, distance and heading.
// ============================================================================
interface gpms_move_if
    import gpms_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [DIST_WIDTH-1:0]        distance;
    logic signed [HEAD_WIDTH-1:0] heading;
    logic                         last_result;

    modport source (output valid, kind, distance, heading, last_result, input ready);
    modport sink   (input valid, kind, distance, heading, last_result, output ready);
endinterface

@@ rtl/gpms_cordic.sv @@
// ============================================================================
// gpms_cordic - bit-serial CORDIC vectoring unit
// Converts a goal point to magnitude and heading, one bit of x, y and z per
// cycle, then applies the gain correction with a serial-parallel multiply.
// ============================================================================
module gpms_cordic
    import gpms_pkg::*;
#(
    parameter int COORD_WIDTH  = GPMS_COORD_WIDTH,
    parameter int CORDIC_STEPS = GPMS_CORDIC_STEPS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] goal_x,
    input  logic signed [COORD_WIDTH-1:0] goal_y,
    output gpms_polar_t                   polar
);

    localparam int XW     = COORD_WIDTH + GUARD_BITS + 3;
    localparam int SW     = (XW > ANGLE_WIDTH) ? XW : ANGLE_WIDTH;
    localparam int RUN    = (SW > PROD_BITS) ? SW : PROD_BITS;
    localparam int CNT_W  = $clog2(RUN);
    localparam int SIDX_W = $clog2(SW);
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    gpms_cstate_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [SW-1:0] xr_reg, xr_next;
    logic [SW-1:0] yr_reg, yr_next;
    logic [SW-1:0] zr_reg, zr_next;
    logic xsgn_reg, xsgn_next;
    logic ysgn_reg, ysgn_next;
    logic zsgn_reg, zsgn_next;
    logic yzero_reg, yzero_next;
    logic yacc_reg, yacc_next;
    logic cx_reg, cx_next;
    logic cy_reg, cy_next;
    logic cz_reg, cz_next;
    logic ca_reg, ca_next;
    logic pi_reg, pi_next;
    logic [31:0]           acc_reg, acc_next;
    logic [DIST_WIDTH:0]   prod_reg, prod_next;
    logic [HEAD_WIDTH:0]   ang_reg, ang_next;

    // load values
    logic signed [COORD_WIDTH:0] gxe, gye, vx, vy;
    logic [SW-1:0]               x_init, y_init, z_init;

    // serial datapath
    logic              first, last_bit, in_range, ypos, yneg;
    logic [SIDX_W-1:0] sidx;
    logic [SW-1:0]     atan_ext;
    logic              xs, ys, ab, opx, opy, opz, cx_in, cy_in, cz_in;
    logic              nx, ny, nz, yor;
    logic              ubit, nb, azb, ca_in;
    logic [31:0]       acc_in, addend;
    logic [32:0]       psum;

    // result
    logic [HEAD_WIDTH:0]   hsum;
    logic [HEAD_WIDTH-1:0] hmag;

    always_comb
    begin
        gxe = {goal_x[COORD_WIDTH-1], goal_x};
        gye = {goal_y[COORD_WIDTH-1], goal_y};
        // turn a vector in the left half plane by +-pi/2 first
        if (gxe < 0)
        begin
            if (gye >= 0)
            begin
                vx     = gye;
                vy     = -gxe;
                z_init = HALF_PI_Q30 & {ANGLE_WIDTH{1'b1}} ;
            end
            else
            begin
                vx     = -gye;
                vy     = gxe;
                z_init = SW'(-$signed({1'b0, HALF_PI_Q30}));
            end
        end
        else
        begin
            vx     = gxe;
            vy     = gye;
            z_init = '0;
        end
        x_init = SW'(vx) << GUARD_BITS;
        y_init = SW'(vy) << GUARD_BITS;
    end

    always_comb
    begin
        first    = (cnt_reg == '0);
        last_bit = (cnt_reg == CNT_W'(SW - 1));
        in_range = (int'(cnt_reg) + int'(step_reg)) < SW;
        ypos     = !ysgn_reg && !yzero_reg;
        yneg     = ysgn_reg;
        sidx     = SIDX_W'(step_reg);
        atan_ext = SW'(atan_entry(5'(step_reg)));

        // arithmetic shift by step: past the top, repeat the sign
        xs = in_range ? xr_reg[sidx] : xsgn_reg;
        ys = in_range ? yr_reg[sidx] : ysgn_reg;
        ab = atan_ext[cnt_reg[SIDX_W-1:0]];

        // subtraction as add of the inverted operand with carry in
        opx   = yneg ? ~ys : ys;
        opy   = ypos ? ~xs : xs;
        opz   = yneg ? ~ab : ab;
        cx_in = first ? yneg : cx_reg;
        cy_in = first ? ypos : cy_reg;
        cz_in = first ? yneg : cz_reg;

        if (yzero_reg)
        begin
            nx = xr_reg[0];
            ny = yr_reg[0];
            nz = zr_reg[0];
        end
        else
        begin
            nx = xr_reg[0] ^ opx ^ cx_in;
            ny = yr_reg[0] ^ opy ^ cy_in;
            nz = zr_reg[0] ^ opz ^ cz_in;
        end
        yor = (first ? 1'b0 : yacc_reg) | ny;

        // post pass: |z| by serial negation, x * gain by serial-parallel multiply
        ubit   = xr_reg[0] & !xsgn_reg;
        acc_in = first ? '0 : acc_reg;
        addend = ubit ? INV_GAIN_Q32 : '0;
        psum   = {1'b0, acc_in} + {1'b0, addend};
        ca_in  = first ? zsgn_reg : ca_reg;
        nb     = zr_reg[0] ^ zsgn_reg;
        azb    = nb ^ ca_in;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        xr_next    = xr_reg;
        yr_next    = yr_reg;
        zr_next    = zr_reg;
        xsgn_next  = xsgn_reg;
        ysgn_next  = ysgn_reg;
        zsgn_next  = zsgn_reg;
        yzero_next = yzero_reg;
        yacc_next  = yacc_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        ca_next    = ca_reg;
        pi_next    = pi_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        ang_next   = ang_reg;

        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    xr_next    = x_init;
                    yr_next    = y_init;
                    zr_next    = z_init;
                    xsgn_next  = x_init[SW-1];
                    ysgn_next  = y_init[SW-1];
                    zsgn_next  = z_init[SW-1];
                    yzero_next = (vy == '0);
                    pi_next    = (gye == '0) && (gxe < 0);
                    cnt_next   = '0;
                    step_next  = '0;
                    state_next = CS_ITER;
                end
            end
            CS_ITER:
            begin
                xr_next   = {nx, xr_reg[SW-1:1]};
                yr_next   = {ny, yr_reg[SW-1:1]};
                zr_next   = {nz, zr_reg[SW-1:1]};
                cx_next   = (xr_reg[0] & opx) | (cx_in & (xr_reg[0] ^ opx));
                cy_next   = (yr_reg[0] & opy) | (cy_in & (yr_reg[0] ^ opy));
                cz_next   = (zr_reg[0] & opz) | (cz_in & (zr_reg[0] ^ opz));
                yacc_next = yor;
                if (last_bit)
                begin
                    xsgn_next  = nx;
                    ysgn_next  = ny;
                    zsgn_next  = nz;
                    yzero_next = !yor;
                    cnt_next   = '0;
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    begin
                        state_next = CS_POST;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            CS_POST:
            begin
                xr_next  = {1'b0, xr_reg[SW-1:1]};
                zr_next  = {zsgn_reg, zr_reg[SW-1:1]};
                acc_next = psum[32:1];
                ca_next  = nb & ca_in;
                if ((cnt_reg >= CNT_W'(PROD_ROUND_BIT))
                    && (cnt_reg < CNT_W'(PROD_ROUND_BIT + DIST_WIDTH + 1)))
                begin
                    prod_next = {psum[0], prod_reg[DIST_WIDTH:1]};
                end
                if ((cnt_reg >= CNT_W'(ANG_ROUND_BIT))
                    && (cnt_reg < CNT_W'(ANG_ROUND_BIT + HEAD_WIDTH + 1)))
                begin
                    ang_next = {azb, ang_reg[HEAD_WIDTH:1]};
                end
                if (cnt_reg == CNT_W'(PROD_BITS - 1))
                begin
                    state_next = CS_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            CS_DONE:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        step_reg  <= step_next;
        xr_reg    <= xr_next;
        yr_reg    <= yr_next;
        zr_reg    <= zr_next;
        xsgn_reg  <= xsgn_next;
        ysgn_reg  <= ysgn_next;
        zsgn_reg  <= zsgn_next;
        yzero_reg <= yzero_next;
        yacc_reg  <= yacc_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        ca_reg    <= ca_next;
        pi_reg    <= pi_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        ang_reg   <= ang_next;
    end

    // round half away from zero, saturate at pi, restore the sign
    always_comb
    begin
        hsum = {1'b0, ang_reg[HEAD_WIDTH:1]} + {{HEAD_WIDTH{1'b0}}, ang_reg[0]};
        hmag = (hsum > {1'b0, PI_Q13}) ? PI_Q13 : hsum[HEAD_WIDTH-1:0];

        polar.done     = (state_reg == CS_DONE);
        polar.distance = prod_reg[DIST_WIDTH:1]
                         + {{(DIST_WIDTH-1){1'b0}}, prod_reg[0]};
        if (pi_reg)
        begin
            polar.heading = PI_Q13;
        end
        else
        begin
            polar.heading = zsgn_reg ? -hmag : hmag;
        end
    end

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == CS_IDLE))
        else $error("cordic started while a conversion is running");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        polar.done |=> !polar.done)
        else $error("cordic done held for more than one cycle");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_ITER) |-> (cnt_reg < CNT_W'(SW)))
        else $error("cordic bit counter ran past the word");

endmodule

@@ rtl/goal_to_polar_move_sequencer.sv @@
// ============================================================================
// goal_to_polar_move_sequencer - goal point to polar move command sequencer
// Turns goal points into move commands (distance, heading) and pairs them
// with movement-done acknowledgements to issue goal reached notices.
// ============================================================================
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ----------------------------------------------
//  goal     in   valid / ready  cmd, goal_x, goal_y, last
//  move     out  valid / ready  kind, distance, heading, last_result
//
//  A nonzero goal taken while idle starts the CORDIC, whose serial words are
//  SW = max(COORD_WIDTH + 15, 33) bits wide: each CORDIC step moves x, y and
//  the angle through the bit-serial adders one bit a cycle, then the gain
//  correction runs as a serial-parallel multiply.
//  Acknowledgements that end no move and dropped goals leave the sequencer idle;
//  a zero goal, an acknowledgement that ends a move and a move with a pending
//  acknowledgement pass on to the state that loads goal reached.
//  Reset clears the sequencer and the CORDIC control; there is no sweep.
//  Results sit in an output register; a full register with move.ready low
//  holds the emit states, and goal.ready is high only while idle.
//
module goal_to_polar_move_sequencer
    import gpms_pkg::*;
#(
    parameter int COORD_WIDTH  = GPMS_COORD_WIDTH,
    parameter int CORDIC_STEPS = GPMS_CORDIC_STEPS
) (
    input  logic       clk,
    input  logic       rst_n,
    gpms_goal_if.sink  goal,
    gpms_move_if.source move
);

    gpms_state_t state_reg, state_next;
    logic busy_reg, busy_next;
    logic ack_pending_reg, ack_pending_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         kind_reg, kind_next;
    logic [DIST_WIDTH-1:0]        dist_reg, dist_next;
    logic signed [HEAD_WIDTH-1:0] head_reg, head_next;
    logic                         last_reg, last_next;

    logic        accept, goal_zero, out_free, load_out, start;
    gpms_polar_t polar;

    gpms_cordic #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .goal_x (goal.goal_x),
        .goal_y (goal.goal_y),
        .polar  (polar)
    );

    assign goal.ready       = (state_reg == ST_IDLE);
    assign accept           = goal.valid && goal.ready;
    assign goal_zero        = (goal.goal_x == '0) && (goal.goal_y == '0);
    assign out_free         = !out_valid_reg || move.ready;

    assign move.valid       = out_valid_reg;
    assign move.kind        = kind_reg;
    assign move.distance    = dist_reg;
    assign move.heading     = head_reg;
    assign move.last_result = last_reg;

    always_comb
    begin
        state_next       = state_reg;
        busy_next        = busy_reg;
        ack_pending_next = ack_pending_reg;
        start            = 1'b0;
        load_out         = 1'b0;
        kind_next        = kind_reg;
        dist_next        = dist_reg;
        head_next        = head_reg;
        last_next        = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (goal.cmd == CMD_ACK)
                    begin
                        if (busy_reg)
                        begin
                            busy_next        = 1'b0;
                            ack_pending_next = 1'b0;
                            state_next       = ST_EMIT_REACH;
                        end
                        else
                        begin
                            ack_pending_next = 1'b1;
                        end
                    end
                    else if (!busy_reg)
                    begin
                        // drop goals while a move is under way
                        if (goal_zero)
                        begin
                            state_next = ST_EMIT_REACH;
                        end
                        else
                        begin
                            start      = 1'b1;
                            state_next = ST_SOLVE;
                        end
                    end
                end
            end
            ST_SOLVE:
            begin
                if (polar.done)
                begin
                    state_next = ST_EMIT_MOVE;
                end
            end
            ST_EMIT_MOVE:
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    kind_next = KIND_MOVE;
                    dist_next = polar.distance;
                    head_next = polar.heading;
                    last_next = !ack_pending_reg;
                    if (ack_pending_reg)
                    begin
                        // the move is already acknowledged: goal reached is the next result
                        ack_pending_next = 1'b0;
                        state_next       = ST_EMIT_REACH;
                    end
                    else
                    begin
                        busy_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_REACH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    kind_next  = KIND_REACHED;
                    dist_next  = '0;
                    head_next  = '0;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (move.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            busy_reg        <= 1'b0;
            ack_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            busy_reg        <= busy_next;
            ack_pending_reg <= ack_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        dist_reg <= dist_next;
        head_reg <= head_next;
        last_reg <= last_next;
    end

    a_done_in_solve: assert property (@(posedge clk) disable iff (!rst_n)
        polar.done |-> (state_reg == ST_SOLVE))
        else $error("cordic result arrived outside a conversion");

    a_busy_ack_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && ack_pending_reg))
        else $error("busy and pending acknowledgement set together");

    a_reach_follows_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_MOVE && out_free && ack_pending_reg)
        |=> (state_reg == ST_EMIT_REACH && !busy_reg))
        else $error("pending acknowledgement did not produce goal reached");

endmodule
